@@ sv/clock_command_frame_parser_assert.svh @@
// Assertion macros shared by the clock command frame parser RTL.
// Depends on nothing; each macro expects signals named clock and reset in scope.
`ifndef CLOCK_COMMAND_FRAME_PARSER_ASSERT_SVH
`define CLOCK_COMMAND_FRAME_PARSER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define CCFP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CCFP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/ccfp_pkg.sv @@
// Types, codes and BCD helpers for the clock command frame parser.
// No dependencies.
package ccfp_pkg;

   localparam logic [7:0] TERMINATOR_BYTE = 8'hAA;

   // command bytes
   localparam logic [2:0] CMD_SET_TIME    = 3'd1;
   localparam logic [2:0] CMD_SET_ALARM   = 3'd2;
   localparam logic [2:0] CMD_ALARM_MEL   = 3'd3;
   localparam logic [2:0] CMD_ALARM_SW    = 3'd4;
   localparam logic [2:0] CMD_TEMPERATURE = 3'd5;
   localparam logic [2:0] CMD_SCREEN_SW   = 3'd6;
   localparam logic [2:0] CMD_SCREEN_OFF  = 3'd7;

   // event kinds
   localparam logic [2:0] EVT_SET_TIME    = 3'd0;
   localparam logic [2:0] EVT_SET_ALARM   = 3'd1;
   localparam logic [2:0] EVT_ALARM_SW    = 3'd2;
   localparam logic [2:0] EVT_SCREEN_SW   = 3'd3;
   localparam logic [2:0] EVT_SCREEN_OFF  = 3'd4;
   localparam logic [2:0] EVT_TEMPERATURE = 3'd5;

   // CSR indexes
   localparam logic [7:0] CSR_ALARM_SLOTS  = 8'd0;
   localparam logic [7:0] CSR_MELODY_SLOTS = 8'd1;

   localparam logic [7:0] NO_MELODY = 8'hFF;

   typedef struct packed {
      logic       enable_flag;
      logic [7:0] melody_choice;
      logic [7:0] alarm_slot;
      logic [5:0] second_value;
      logic [5:0] minute_value;
      logic [4:0] hour_value;
      logic       send_ack;
   } rsp_data_type;

   function automatic logic bcd_ok(input logic [7:0] v);
      return (v[3:0] <= 4'd9) && (v[7:4] <= 4'd9);
   endfunction

   // tens * 10 + ones, at most 99 for any 4-bit digits that pass bcd_ok
   function automatic logic [6:0] bcd_value(input logic [7:0] v);
      logic [6:0] tens;
      tens = {3'b000, v[7:4]};
      return (tens << 3) + (tens << 1) + {3'b000, v[3:0]};
   endfunction

endpackage

@@ sv/clock_command_frame_parser.sv @@
// Clock command frame parser: byte stream in, decoded command events out.
// Uses ccfp_pkg and the assertion macros in clock_command_frame_parser_assert.svh.
//
// Usage:
//   req_*  : one received serial byte per transaction (req_tdata[7:0]).
//   rsp_*  : one decoded event per valid frame; rsp_tuser carries the event kind,
//            rsp_tdata the decoded fields.
//   csr_*  : register writes (index 0 alarm slots, index 1 melody slots);
//            csr_ready is always high. Write only while no frame is in flight.
// A frame is a command byte 1..7, its payload and a 0xAA terminator. Frames that
// fail a range, BCD or terminator check are dropped without an event.
// The event appears on rsp_* in the cycle after the terminator byte is accepted.
// Throughput: one byte per cycle while not stalled; the whole decode sits between
// the frame state registers and the single response register.
// Stall: while an event waits unaccepted, req_tready stays low; it is high
// whenever the response register is empty or being drained in that cycle.
// Reset: the parser returns to waiting for a command byte, the response register
// empties, and the slot counts return to 4 alarms and 8 melodies.
`include "clock_command_frame_parser_assert.svh"

module clock_command_frame_parser
   import ccfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [0] send_ack, [5:1] hour_value, [11:6] minute_value,
                                    // [17:12] second_value, [25:18] alarm_slot,
                                    // [33:26] melody_choice, [34] enable_flag, rest zero
   output logic [2:0]  rsp_tuser,   // [2:0] event_kind
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [7:0]  csr_data
);

   logic [7:0]   alarm_slots_ff, alarm_slots_in;
   logic [7:0]   melody_slots_ff, melody_slots_in;
   logic [2:0]   position_ff, position_in;
   logic [2:0]   command_ff, command_in;
   logic [7:0]   payload_ff [4];
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff, rsp_data_in;
   logic [2:0]   rsp_kind_ff, rsp_kind_in;

   logic         accept;
   logic         store;
   logic [1:0]   store_idx;
   logic [2:0]   payload_len;
   logic         emit;
   logic         is_term;
   logic         alarm_ok;
   logic         melody_ok;
   logic [6:0]   bcd0, bcd1, bcd2;
   rsp_data_type evt;
   logic [2:0]   evt_kind;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000, rsp_data_ff};
   assign rsp_tuser  = rsp_kind_ff;

   always_comb begin
      case (command_ff)
         CMD_SCREEN_SW: payload_len = 3'd1;
         CMD_ALARM_SW:  payload_len = 3'd2;
         CMD_ALARM_MEL: payload_len = 3'd4;
         default:       payload_len = 3'd3;
      endcase
   end

   assign is_term   = (req_tdata == TERMINATOR_BYTE);
   assign store_idx = position_ff[1:0] - 2'd1;
   assign alarm_ok  = (payload_ff[0] != 8'd0) && (payload_ff[0] <= alarm_slots_ff);
   assign melody_ok = (payload_ff[3] != 8'd0) && (payload_ff[3] <= melody_slots_ff);
   assign bcd0      = bcd_value(payload_ff[0]);
   assign bcd1      = bcd_value(payload_ff[1]);
   assign bcd2      = bcd_value(payload_ff[2]);

   // frame tracking and event decode for the byte on req_tdata
   always_comb begin
      position_in = position_ff;
      command_in  = command_ff;
      store       = 1'b0;
      emit        = 1'b0;
      evt         = '0;
      evt_kind    = EVT_SET_TIME;
      evt.send_ack = 1'b1;
      if (position_ff == 3'd0) begin
         if (req_tdata >= 8'd1 && req_tdata <= 8'd7) begin
            command_in  = req_tdata[2:0];
            position_in = 3'd1;
         end
      end else if (command_ff == CMD_TEMPERATURE || command_ff == CMD_SCREEN_OFF) begin
         position_in = 3'd0;
         emit        = is_term;
         if (command_ff == CMD_TEMPERATURE) begin
            evt_kind     = EVT_TEMPERATURE;
            evt.send_ack = 1'b0;
         end else begin
            evt_kind = EVT_SCREEN_OFF;
         end
      end else if (position_ff <= payload_len) begin
         store       = 1'b1;
         position_in = position_ff + 3'd1;
      end else begin
         position_in = 3'd0;
         case (command_ff)
            CMD_SET_TIME: begin
               evt_kind         = EVT_SET_TIME;
               evt.hour_value   = bcd0[4:0];
               evt.minute_value = bcd1[5:0];
               evt.second_value = bcd2[5:0];
               emit = is_term && bcd_ok(payload_ff[0]) && bcd_ok(payload_ff[1])
                      && bcd_ok(payload_ff[2]) && bcd0 < 7'd24 && bcd1 < 7'd60
                      && bcd2 < 7'd60;
            end
            CMD_SET_ALARM, CMD_ALARM_MEL: begin
               evt_kind          = EVT_SET_ALARM;
               evt.hour_value    = bcd1[4:0];
               evt.minute_value  = bcd2[5:0];
               evt.alarm_slot    = payload_ff[0] - 8'd1;
               evt.melody_choice = (command_ff == CMD_ALARM_MEL) ?
                                   payload_ff[3] - 8'd1 : NO_MELODY;
               emit = is_term && alarm_ok && bcd_ok(payload_ff[1])
                      && bcd_ok(payload_ff[2]) && bcd1 < 7'd24 && bcd2 < 7'd60
                      && (command_ff != CMD_ALARM_MEL || melody_ok);
            end
            CMD_ALARM_SW: begin
               evt_kind        = EVT_ALARM_SW;
               evt.alarm_slot  = payload_ff[0] - 8'd1;
               evt.enable_flag = payload_ff[1][0];
               emit = is_term && alarm_ok && (payload_ff[1][7:1] == 7'd0);
            end
            CMD_SCREEN_SW: begin
               evt_kind        = EVT_SCREEN_SW;
               evt.enable_flag = payload_ff[0][0];
               emit = is_term && (payload_ff[0][7:1] == 7'd0);
            end
            default: emit = 1'b0;
         endcase
      end
   end

   always_comb begin
      alarm_slots_in  = alarm_slots_ff;
      melody_slots_in = melody_slots_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ALARM_SLOTS:  alarm_slots_in  = csr_data;
            CSR_MELODY_SLOTS: melody_slots_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;
      if (accept) begin
         rsp_valid_in = emit;
         if (emit) begin
            rsp_data_in = evt;
            rsp_kind_in = evt_kind;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alarm_slots_ff  <= 8'd4;
         melody_slots_ff <= 8'd8;
         position_ff     <= 3'd0;
         command_ff      <= 3'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         alarm_slots_ff  <= alarm_slots_in;
         melody_slots_ff <= melody_slots_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (accept) begin
            position_ff <= position_in;
            command_ff  <= command_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
      if (accept && store) begin
         payload_ff[store_idx] <= req_tdata;
      end
   end

   `CCFP_ASSERT_NOW(a_position_range, 1'b1, position_ff <= 3'd5,
      "frame position beyond last payload byte")
   `CCFP_ASSERT_NOW(a_event_after_term, $rose(rsp_valid_ff),
      $past(accept) && $past(req_tdata) == TERMINATOR_BYTE,
      "event produced without an accepted terminator")
   `CCFP_ASSERT_NEXT(a_junk_ignored,
      accept && position_ff == 3'd0 && (req_tdata == 8'd0 || req_tdata > 8'd7),
      position_ff == 3'd0, "non-command byte started a frame")
   `CCFP_ASSERT_NOW(a_ack_only_temp, rsp_valid_ff && !rsp_data_ff.send_ack,
      rsp_kind_ff == EVT_TEMPERATURE, "missing acknowledge on non-temperature event")

endmodule
